// ----- rtl/wtor_pkg.sv -----
// Package for the wavetable oscillator renderer.
// Holds register indexes, reset values, opcodes, format codes and default sizes.
// No dependencies.
package wtor_pkg;

    localparam int TABLE_ENTRIES_DEF = 4096;
    localparam int MAX_CHANNELS_DEF  = 32;

    localparam logic [2:0] CFG_TABLE_LEN  = 3'd0;
    localparam logic [2:0] CFG_WAVE_LEN   = 3'd1;
    localparam logic [2:0] CFG_TABLE_MASK = 3'd2;
    localparam logic [2:0] CFG_VOLUME     = 3'd3;
    localparam logic [2:0] CFG_CH_COUNT   = 3'd4;
    localparam logic [2:0] CFG_CH_MASK    = 3'd5;
    localparam logic [2:0] CFG_OUT_FMT    = 3'd6;

    localparam logic [23:0] RST_TABLE_LEN  = 24'd4096;
    localparam logic [23:0] RST_WAVE_LEN   = 24'd4096;
    localparam logic [11:0] RST_TABLE_MASK = 12'd4095;
    localparam logic [15:0] RST_VOLUME     = 16'd65535;
    localparam logic [5:0]  RST_CH_COUNT   = 6'd1;
    localparam logic [31:0] RST_CH_MASK    = 32'd1;
    localparam logic [1:0]  RST_OUT_FMT    = 2'd1;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    localparam logic [1:0] FMT_8  = 2'd0;
    localparam logic [1:0] FMT_16 = 2'd1;
    localparam logic [1:0] FMT_24 = 2'd2;
    localparam logic [1:0] FMT_32 = 2'd3;

endpackage

// ----- rtl/wtor_udiv.sv -----
// Pipelined restoring divider, one quotient bit per stage, with sideband words.
// Depends on nothing but the clock enable from its user.
module wtor_udiv #(
    parameter int NW = 56,
    parameter int DW = 24,
    parameter int SW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [NW-1:0] o_quo,
    output logic [DW-1:0] o_rem,
    output logic [SW-1:0] o_side
);

    logic          r_v    [NW];
    logic [DW-1:0] r_rem  [NW];
    logic [NW-1:0] r_num  [NW];
    logic [DW-1:0] r_den  [NW];
    logic [SW-1:0] r_side [NW];

    genvar k;
    for (k = 0; k < NW; k++) begin : g_stage
        logic          p_v;
        logic [DW-1:0] p_rem;
        logic [NW-1:0] p_num;
        logic [DW-1:0] p_den;
        logic [SW-1:0] p_side;
        logic [DW:0]   w_sh;
        logic [DW:0]   w_diff;
        logic          w_ge;

        if (k == 0) begin : g_first
            assign p_v    = i_valid;
            assign p_rem  = '0;
            assign p_num  = i_num;
            assign p_den  = i_den;
            assign p_side = i_side;
        end else begin : g_next
            assign p_v    = r_v[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_num  = r_num[k-1];
            assign p_den  = r_den[k-1];
            assign p_side = r_side[k-1];
        end

        assign w_sh   = {p_rem, p_num[NW-1]};
        assign w_diff = w_sh - {1'b0, p_den};
        assign w_ge   = !w_diff[DW];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_ge ? w_diff[DW-1:0] : w_sh[DW-1:0];
                r_num[k]  <= {p_num[NW-2:0], w_ge};
                r_den[k]  <= p_den;
                r_side[k] <= p_side;
            end
        end
    end

    assign o_valid = r_v[NW-1];
    assign o_quo   = r_num[NW-1];
    assign o_rem   = r_rem[NW-1];
    assign o_side  = r_side[NW-1];

endmodule

// ----- rtl/wtor_table.sv -----
// Wave table storage: two copies give two registered reads per cycle while i_en is high.
// Depends on wtor_pkg for the default depth.
module wtor_table #(
    parameter int TABLE_ENTRIES = wtor_pkg::TABLE_ENTRIES_DEF,
    parameter int AW = $clog2(TABLE_ENTRIES + 1)
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic signed [15:0] i_wdata,
    input  logic [AW-1:0]      i_raddr_a,
    input  logic [AW-1:0]      i_raddr_b,
    output logic signed [15:0] o_rdata_a,
    output logic signed [15:0] o_rdata_b
);

    localparam int DEPTH = TABLE_ENTRIES + 1;

    logic signed [15:0] r_mem_a [DEPTH];
    logic signed [15:0] r_mem_b [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en && i_we) begin
            r_mem_a[i_waddr] <= i_wdata;
            r_mem_b[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rdata_a <= r_mem_a[i_raddr_a];
            o_rdata_b <= r_mem_b[i_raddr_b];
        end
    end

endmodule

// ----- rtl/wtor_emit.sv -----
// Channel sequencer: turns one finished sample into one word per channel.
// Depends on wtor_pkg for the default channel limit.
module wtor_emit #(
    parameter int MAX_CHANNELS = wtor_pkg::MAX_CHANNELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [31:0] i_sample,
    output logic        o_take,
    input  logic [5:0]  i_ch_count,
    input  logic [31:0] i_ch_mask,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_sample,
    output logic [4:0]  o_channel,
    output logic        o_last
);

    logic        r_valid;
    logic [31:0] r_smp;
    logic [31:0] r_out;
    logic [4:0]  r_ch;
    logic [5:0]  r_n;
    logic        r_last;
    logic [5:0]  w_n;
    logic [4:0]  w_next_ch;
    logic        w_load;
    logic        w_step;

    assign w_n       = (i_ch_count > 6'(MAX_CHANNELS)) ? 6'(MAX_CHANNELS) : i_ch_count;
    assign o_take    = !r_valid || (i_ready && r_last);
    assign w_load    = i_valid && o_take;
    assign w_step    = r_valid && i_ready && !r_last;
    assign w_next_ch = r_ch + 5'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= (w_n != 6'd0);
        end else if (r_valid && i_ready && r_last) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_smp  <= i_sample;
            r_n    <= w_n;
            r_ch   <= 5'd0;
            r_last <= (w_n == 6'd1);
            r_out  <= i_ch_mask[0] ? i_sample : 32'd0;
        end else if (w_step) begin
            r_ch   <= w_next_ch;
            r_last <= ({1'b0, w_next_ch} + 6'd1 == r_n);
            r_out  <= i_ch_mask[w_next_ch] ? r_smp : 32'd0;
        end
    end

    assign o_valid   = r_valid;
    assign o_sample  = r_out;
    assign o_channel = r_ch;
    assign o_last    = r_last;

endmodule

// ----- rtl/wavetable_oscillator_render.sv -----
// Top level of the wavetable oscillator renderer.
// Depends on wtor_pkg, wtor_udiv, wtor_table and wtor_emit.
//
// Input words arrive on the s channel: tuser is the opcode (0 load, 1 render),
// tdata holds table_index, table_value and frame_number from the lowest bit.
// A load writes one table word if table_index is at most TABLE_ENTRIES; a render
// yields channel_count words, at most MAX_CHANNELS, on the m channel, one per cycle
// while the receiver is ready, with tlast on the final channel of the frame.
// Registers are written on the cfg channel, which is ready whenever reset is released;
// the user must write them only while the block is idle; the block does not enforce it.
// A new word is accepted every cycle while the output is free. The path is a pipeline
// of 97 register stages, set by the 56-stage quotient divider and the 31-stage
// interpolation divider. A render with several channels holds the pipeline at the
// output until its last word is taken, so sustained throughput is one channel word
// per cycle while the receiver is ready. When the receiver stalls, the whole pipeline
// holds and no word is lost. Reset restores the register defaults and empties the
// pipeline; no word is accepted while it is held, and the table is undefined until written.
module wavetable_oscillator_render #(
    parameter int TABLE_ENTRIES = wtor_pkg::TABLE_ENTRIES_DEF,
    parameter int MAX_CHANNELS  = wtor_pkg::MAX_CHANNELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // table_index[12:0], table_value[28:13], frame_number[60:29], zero fill
    input  logic [63:0] i_s_tdata,
    // opcode
    input  logic        i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // sample[31:0], output_channel[36:32], zero fill
    output logic [39:0] o_m_tdata,
    output logic        o_m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    import wtor_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES + 1);

    logic [23:0] r_tlen;
    logic [23:0] r_wlen;
    logic [11:0] r_tmask;
    logic [15:0] r_vol;
    logic [5:0]  r_ch_count;
    logic [31:0] r_ch_mask;
    logic [1:0]  r_fmt;

    logic w_en;
    logic w_take;

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tlen     <= RST_TABLE_LEN;
            r_wlen     <= RST_WAVE_LEN;
            r_tmask    <= RST_TABLE_MASK;
            r_vol      <= RST_VOLUME;
            r_ch_count <= RST_CH_COUNT;
            r_ch_mask  <= RST_CH_MASK;
            r_fmt      <= RST_OUT_FMT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TABLE_LEN:  r_tlen     <= i_cfg_data[23:0];
                CFG_WAVE_LEN:   r_wlen     <= i_cfg_data[23:0];
                CFG_TABLE_MASK: r_tmask    <= i_cfg_data[11:0];
                CFG_VOLUME:     r_vol      <= i_cfg_data[15:0];
                CFG_CH_COUNT:   r_ch_count <= i_cfg_data[5:0];
                CFG_CH_MASK:    r_ch_mask  <= i_cfg_data;
                CFG_OUT_FMT:    r_fmt      <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // Input and product stages.
    logic               r0_v;
    logic               r0_op;
    logic [12:0]        r0_idx;
    logic signed [15:0] r0_val;
    logic [31:0]        r0_frame;
    logic               r1_v;
    logic [29:0]        r1_side;
    logic [55:0]        r1_prod;

    assign o_s_tready = w_en && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
        end else if (w_en) begin
            r0_v <= i_s_tvalid;
            r1_v <= r0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_op    <= i_s_tuser;
            r0_idx   <= i_s_tdata[12:0];
            r0_val   <= i_s_tdata[28:13];
            r0_frame <= i_s_tdata[60:29];
            r1_side  <= {r0_op, r0_idx, r0_val};
            r1_prod  <= r0_frame * r_tlen;
        end
    end

    logic        d1_v;
    logic [55:0] d1_quo;
    logic [23:0] d1_rem;
    logic [29:0] d1_side;

    wtor_udiv #(.NW(56), .DW(24), .SW(30)) u_qdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r1_v),
        .i_num   (r1_prod),
        .i_den   (r_wlen),
        .i_side  (r1_side),
        .o_valid (d1_v),
        .o_quo   (d1_quo),
        .o_rem   (d1_rem),
        .o_side  (d1_side)
    );

    // Table stage: index, shift and table access.
    logic        w_wl0;
    logic [26:0] w_wl5;
    logic        w_interp;
    logic [11:0] w_p;
    logic [12:0] w_p1;
    logic [23:0] w_r;
    logic [4:0]  w_len;
    logic [3:0]  w_s;
    logic        w_load_ok;
    logic        w_op;
    logic [12:0] w_lidx;
    logic signed [15:0] w_lval;

    assign w_op   = d1_side[29];
    assign w_lidx = d1_side[28:16];
    assign w_lval = d1_side[15:0];
    assign w_wl0  = (r_wlen == 24'd0);
    assign w_wl5  = {3'b0, r_wlen} + {1'b0, r_wlen, 2'b0};
    assign w_interp = !w_wl0 && ({3'b0, r_tlen} < w_wl5);
    assign w_p    = (w_wl0 ? 12'd0 : d1_quo[11:0]) & r_tmask;
    assign w_p1   = {1'b0, w_p} + 13'd1;
    assign w_r    = w_wl0 ? 24'd0 : d1_rem;
    assign w_load_ok = d1_v && (w_op == OP_LOAD) && (32'(w_lidx) <= 32'(TABLE_ENTRIES));

    always_comb begin
        w_len = 5'd0;
        for (int i = 0; i < 24; i++) begin
            if (w_r[i]) begin
                w_len = 5'(i + 1);
            end
        end
        w_s = (w_len > 5'd19) ? 4'(w_len - 5'd15) : 4'd4;
    end

    logic               rm_v;
    logic               rm_interp;
    logic               rm_aok;
    logic               rm_bok;
    logic [14:0]        rm_frac;
    logic [19:0]        rm_den;
    logic signed [15:0] w_ta;
    logic signed [15:0] w_tb;

    wtor_table #(.TABLE_ENTRIES(TABLE_ENTRIES), .AW(AW)) u_table (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_we      (w_load_ok),
        .i_waddr   (AW'(32'(w_lidx))),
        .i_wdata   (w_lval),
        .i_raddr_a (AW'(32'(w_p))),
        .i_raddr_b (AW'(32'(w_p1))),
        .o_rdata_a (w_ta),
        .o_rdata_b (w_tb)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rm_v <= 1'b0;
        end else if (w_en) begin
            rm_v <= d1_v && (w_op == OP_RENDER);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rm_interp <= w_interp;
            rm_aok    <= (32'(w_p) <= 32'(TABLE_ENTRIES));
            rm_bok    <= (32'(w_p1) <= 32'(TABLE_ENTRIES));
            rm_frac   <= 15'(w_r >> w_s);
            rm_den    <= 20'(r_wlen >> w_s);
        end
    end

    // Difference and product stage.
    logic signed [15:0] w_a;
    logic signed [15:0] w_b;
    logic signed [16:0] w_diff;
    logic [16:0]        w_dmag;
    logic [31:0]        w_dprod;
    logic               rd_v;
    logic [30:0]        rd_mag;
    logic [19:0]        rd_den;
    logic [17:0]        rd_side;

    assign w_a     = rm_aok ? w_ta : 16'sd0;
    assign w_b     = rm_bok ? w_tb : 16'sd0;
    assign w_diff  = {w_b[15], w_b} - {w_a[15], w_a};
    assign w_dmag  = w_diff[16] ? 17'(-w_diff) : 17'(w_diff);
    assign w_dprod = w_dmag * rm_frac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rd_v <= 1'b0;
        end else if (w_en) begin
            rd_v <= rm_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rd_mag  <= w_dprod[30:0];
            rd_den  <= rm_den;
            rd_side <= {w_diff[16], rm_interp && (rm_den != 20'd0), w_a};
        end
    end

    logic        d2_v;
    logic [30:0] d2_quo;
    logic [19:0] d2_rem;
    logic [17:0] d2_side;

    wtor_udiv #(.NW(31), .DW(20), .SW(18)) u_fdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (rd_v),
        .i_num   (rd_mag),
        .i_den   (rd_den),
        .i_side  (rd_side),
        .o_valid (d2_v),
        .o_quo   (d2_quo),
        .o_rem   (d2_rem),
        .o_side  (d2_side)
    );

    // Interpolated value, volume scaling and format conversion stages.
    logic [17:0] w_sq;
    logic [17:0] w_sum;
    logic        rv_v;
    logic signed [15:0] rv_val;

    assign w_sq  = d2_side[17] ? 18'(-{1'b0, d2_quo[16:0]}) : {1'b0, d2_quo[16:0]};
    assign w_sum = {{2{d2_side[15]}}, d2_side[15:0]}
                 + (d2_side[16] ? w_sq : 18'd0);

    logic [16:0] w_vm;
    logic [32:0] w_vprod;
    logic        rx_v;
    logic        rx_neg;
    logic [30:0] rx_mag;

    assign w_vm    = rv_val[15] ? 17'(-{rv_val[15], rv_val}) : {1'b0, rv_val};
    assign w_vprod = w_vm * r_vol;

    logic [14:0] w_q0;
    logic [16:0] w_vrem;
    logic        ry_v;
    logic        ry_neg;
    logic [15:0] ry_m;

    assign w_q0   = rx_mag[30:16];
    assign w_vrem = {1'b0, rx_mag[15:0]} + {2'b0, w_q0};

    logic        rz_v;
    logic        rz_neg;
    logic [15:0] rz_m;
    logic [23:0] rz_y;

    logic [8:0]  w_yq;
    logic [15:0] w_yr;
    logic [8:0]  w_yq2;
    logic [23:0] w_mag24;
    logic [31:0] w_mag32;
    logic [16:0] w_w;
    logic [31:0] w_s24;
    logic [31:0] w_s32;
    logic [31:0] w_smp;
    logic        rw_v;
    logic [31:0] rw_smp;

    assign w_yq    = rz_y[23:15];
    assign w_yr    = {1'b0, rz_y[14:0]} + {7'b0, w_yq};
    assign w_yq2   = w_yq + {8'b0, (w_yr >= 16'd32767)};
    assign w_mag24 = {rz_m, 8'b0} + {15'b0, w_yq2};
    assign w_mag32 = {rz_m, 16'b0} + {15'b0, rz_m, 1'b0} + {31'b0, (rz_m >= 16'd32767)};
    assign w_w     = rz_neg ? 17'(-{1'b0, rz_m}) : {1'b0, rz_m};

    always_comb begin
        if (rz_neg) begin
            w_s24 = (w_mag24 > 24'h800000) ? 32'hFF800000 : 32'(-{8'b0, w_mag24});
            w_s32 = (w_mag32 > 32'h80000000) ? 32'h80000000 : 32'(-w_mag32);
        end else begin
            w_s24 = (w_mag24 > 24'h7FFFFF) ? 32'h007FFFFF : {8'b0, w_mag24};
            w_s32 = (w_mag32 > 32'h7FFFFFFF) ? 32'h7FFFFFFF : w_mag32;
        end
        case (r_fmt)
            FMT_8:   w_smp = {{23{w_w[16]}}, w_w[16:8]};
            FMT_16:  w_smp = {{15{w_w[16]}}, w_w};
            FMT_24:  w_smp = w_s24;
            FMT_32:  w_smp = w_s32;
            default: w_smp = w_s32;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rv_v <= 1'b0;
            rx_v <= 1'b0;
            ry_v <= 1'b0;
            rz_v <= 1'b0;
            rw_v <= 1'b0;
        end else if (w_en) begin
            rv_v <= d2_v;
            rx_v <= rv_v;
            ry_v <= rx_v;
            rz_v <= ry_v;
            rw_v <= rz_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            rv_val <= w_sum[15:0];
            rx_neg <= rv_val[15];
            rx_mag <= w_vprod[30:0];
            ry_neg <= rx_neg;
            ry_m   <= {1'b0, w_q0} + {15'b0, (w_vrem >= 17'd65535)};
            rz_neg <= ry_neg;
            rz_m   <= ry_m;
            rz_y   <= ry_m * 24'd255;
            rw_smp <= w_smp;
        end
    end

    assign w_en = !rw_v || w_take;

    logic [31:0] w_out_smp;
    logic [4:0]  w_out_ch;

    wtor_emit #(.MAX_CHANNELS(MAX_CHANNELS)) u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (rw_v),
        .i_sample   (rw_smp),
        .o_take     (w_take),
        .i_ch_count (r_ch_count),
        .i_ch_mask  (r_ch_mask),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_sample   (w_out_smp),
        .o_channel  (w_out_ch),
        .o_last     (o_m_tlast)
    );

    assign o_m_tdata = {3'b0, w_out_ch, w_out_smp};

endmodule

// ----- tb/wavetable_oscillator_render_tb.sv -----
// Self-checking testbench for wavetable_oscillator_render.
// Depends on wtor_pkg and the renderer RTL. A directed table runs first, then random
// words; every channel word is checked against the built-in predictor or a typed value.
module wavetable_oscillator_render_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wtor_pkg::*;

    localparam int         GUARD_IDX  = TABLE_ENTRIES_DEF;
    localparam int         WD_LIMIT   = 20000;
    localparam int         DRAIN_WAIT = 150;
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    typedef enum logic [1:0] {ROW_LOAD, ROW_RENDER, ROW_CFG} row_kind_e;

    typedef struct {
        row_kind_e   kind;
        logic [31:0] arg;
        logic [12:0] idx;
        logic [15:0] val;
        bit          typed;
        logic [31:0] want;
    } stim_row_t;

    typedef struct {
        logic [31:0] sample;
        logic [4:0]  chan;
        logic        last;
    } chan_word_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // Predictor state
    logic signed [15:0] wave_mem [0:GUARD_IDX];
    bit                 wave_written [0:GUARD_IDX];
    logic [23:0]        tls = RST_TABLE_LEN;
    logic [23:0]        wls = RST_WAVE_LEN;
    logic [11:0]        tmask = RST_TABLE_MASK;
    logic [15:0]        vol = RST_VOLUME;
    logic [5:0]         ch_count = RST_CH_COUNT;
    logic [31:0]        ch_mask = RST_CH_MASK;
    logic [1:0]         out_fmt = RST_OUT_FMT;

    chan_word_t  pending_words [$];
    stim_row_t   rows [$];
    int          errors = 0;
    int          idle_pct = 0;
    int          stall_pct = 0;
    int          wd_count = 0;

    always #6 i_clk = ~i_clk;

    wavetable_oscillator_render u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic int read_entry(logic [31:0] idx);
        if (idx > GUARD_IDX) return 0;
        return int'(wave_mem[idx]);
    endfunction

    function automatic void locate(input logic [31:0] frame, output logic [31:0] pos,
                                   output bit interp, output logic [63:0] rem);
        logic [63:0] prod;
        logic [63:0] quot;
        quot = '0;
        rem = '0;
        interp = 0;
        if (wls != 0) begin
            prod = 64'(frame) * 64'(tls);
            quot = prod / 64'(wls);
            rem = prod % 64'(wls);
            interp = (tls / wls) <= 4;
        end
        pos = quot[31:0] & {20'd0, tmask};
    endfunction

    function automatic logic [31:0] render_sample(logic [31:0] frame);
        logic [31:0] pos;
        logic [63:0] rem;
        bit          interp;
        int          a;
        int          b;
        int          v;
        int          sh;
        int          den;
        longint      t;
        locate(frame, pos, interp, rem);
        a = read_entry(pos);
        v = a;
        if (interp) begin
            b = read_entry(pos + 1);
            sh = 4;
            while ((rem >> sh) > 64'h7FFF) sh++;
            den = int'(wls >> sh);
            if (den != 0) v = a + ((b - a) * int'(rem >> sh)) / den;
        end
        v = int'((longint'(v) * longint'(vol)) / 65535);
        case (out_fmt)
            FMT_8:  t = longint'(v >>> 8);
            FMT_16: t = longint'(v);
            FMT_24: begin
                t = (longint'(v) * 64'sh7FFFFF) / 64'sh7FFF;
                if (t < -64'sh800000) t = -64'sh800000;
                if (t > 64'sh7FFFFF) t = 64'sh7FFFFF;
            end
            default: begin
                t = (longint'(v) * 64'sh7FFFFFFF) / 64'sh7FFF;
                if (t < -64'sh80000000) t = -64'sh80000000;
                if (t > 64'sh7FFFFFFF) t = 64'sh7FFFFFFF;
            end
        endcase
        return t[31:0];
    endfunction

    task automatic send_word(logic op, logic [12:0] idx, logic [15:0] val,
                             logic [31:0] frame, bit typed, logic [31:0] want);
        int          gap;
        int          n;
        logic [31:0] smp;
        chan_word_t  w;
        gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 3) : 0;
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {3'b000, frame, val, idx};
        do @(posedge i_clk); while (!s_tready);
        if (op == OP_LOAD) begin
            if (idx <= GUARD_IDX) begin
                wave_mem[idx] = val;
                wave_written[idx] = 1;
            end
        end else begin
            n = (ch_count > MAX_CHANNELS_DEF) ? MAX_CHANNELS_DEF : int'(ch_count);
            smp = typed ? want : render_sample(frame);
            for (int c = 0; c < n; c++) begin
                w.sample = ch_mask[c] ? smp : 32'd0;
                w.chan = 5'(c);
                w.last = (c == n - 1);
                pending_words.push_back(w);
            end
        end
        @(negedge i_clk);
    endtask

    // Loads any entry that the render would read before it was ever written, unless the channel count is zero.
    task automatic send_render(logic [31:0] frame, bit typed, logic [31:0] want);
        logic [31:0] pos;
        logic [63:0] rem;
        bit          interp;
        locate(frame, pos, interp, rem);
        if (ch_count != 0) begin
            if (!wave_written[pos])
                send_word(OP_LOAD, pos[12:0], 16'($urandom), 32'($urandom), 0, '0);
            if (interp && !wave_written[pos + 1])
                send_word(OP_LOAD, 13'(pos + 1), 16'($urandom), 32'($urandom), 0, '0);
        end
        send_word(OP_RENDER, 13'($urandom), 16'($urandom), frame, typed, want);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        wait (pending_words.size() == 0);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge i_clk); while (!cfg_ready);
        case (idx)
            CFG_TABLE_LEN:  tls = data[23:0];
            CFG_WAVE_LEN:   wls = data[23:0];
            CFG_TABLE_MASK: tmask = data[11:0];
            CFG_VOLUME:     vol = data[15:0];
            CFG_CH_COUNT:   ch_count = data[5:0];
            CFG_CH_MASK:    ch_mask = data;
            CFG_OUT_FMT:    out_fmt = data[1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    function automatic void add_row(row_kind_e kind, logic [31:0] arg, logic [12:0] idx,
                                    logic [15:0] val, bit typed, logic [31:0] want);
        stim_row_t r;
        r.kind = kind;
        r.arg = arg;
        r.idx = idx;
        r.val = val;
        r.typed = typed;
        r.want = want;
        rows.push_back(r);
    endfunction

    always @(posedge i_clk) begin : check_out
        chan_word_t e;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word sample=%h chan=%0d last=%b", $realtime,
                         m_tdata[31:0], m_tdata[36:32], m_tlast);
                errors++;
            end else begin
                e = pending_words.pop_front();
                if (m_tdata[31:0] !== e.sample || m_tdata[36:32] !== e.chan
                    || m_tlast !== e.last || m_tdata[39:37] !== 3'b000) begin
                    $display("%0t: expected sample=%h chan=%0d last=%b, got sample=%h chan=%0d last=%b",
                             $realtime, e.sample, e.chan, e.last, m_tdata[31:0],
                             m_tdata[36:32], m_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            wd_count <= 0;
        else
            wd_count <= wd_count + 1;
        if (wd_count >= WD_LIMIT) begin
            $display("wavetable_oscillator_render_tb failed");
            $finish;
        end
    end

    initial begin : stimulus
        int phase_idle [4];
        int phase_stall [4];
        logic [2:0] reg_idx;
        phase_idle = '{0, 63, 0, 7};
        phase_stall = '{0, 0, 63, 7};
        for (int i = 0; i <= GUARD_IDX; i++) begin
            wave_mem[i] = '0;
            wave_written[i] = 0;
        end

        add_row(ROW_LOAD, 0, 13'd0, 16'h7FFF, 0, 0);
        add_row(ROW_LOAD, 0, 13'd1, 16'h8000, 0, 0);
        add_row(ROW_LOAD, 0, 13'd2, 16'h0000, 0, 0);
        add_row(ROW_LOAD, 0, 13'd4095, 16'hFFFF, 0, 0);
        add_row(ROW_LOAD, 0, 13'd4096, 16'd1234, 0, 0);
        add_row(ROW_LOAD, 0, 13'd8191, 16'd5, 0, 0);
        add_row(ROW_LOAD, 0, 13'd4097, 16'd9, 0, 0);
        add_row(ROW_RENDER, 32'd0, 0, 0, 1, 32'h0000_7FFF);
        add_row(ROW_RENDER, 32'd1, 0, 0, 1, 32'hFFFF_8000);
        add_row(ROW_RENDER, 32'd4095, 0, 0, 1, 32'hFFFF_FFFF);
        add_row(ROW_RENDER, 32'hFFFF_FFFF, 0, 0, 1, 32'hFFFF_FFFF);
        add_row(ROW_CFG, 32'(FMT_8), 13'(CFG_OUT_FMT), 0, 0, 0);
        add_row(ROW_RENDER, 32'd0, 0, 0, 1, 32'h0000_007F);
        add_row(ROW_RENDER, 32'd1, 0, 0, 1, 32'hFFFF_FF80);
        add_row(ROW_CFG, 32'(FMT_24), 13'(CFG_OUT_FMT), 0, 0, 0);
        add_row(ROW_RENDER, 32'd1, 0, 0, 1, 32'hFF80_0000);
        add_row(ROW_RENDER, 32'd0, 0, 0, 1, 32'h007F_FFFF);
        add_row(ROW_CFG, 32'(FMT_32), 13'(CFG_OUT_FMT), 0, 0, 0);
        add_row(ROW_RENDER, 32'd1, 0, 0, 1, 32'h8000_0000);
        add_row(ROW_RENDER, 32'd0, 0, 0, 1, 32'h7FFF_FFFF);
        add_row(ROW_CFG, 32'(FMT_16), 13'(CFG_OUT_FMT), 0, 0, 0);
        add_row(ROW_CFG, 32'd0, 13'(CFG_VOLUME), 0, 0, 0);
        add_row(ROW_RENDER, 32'd0, 0, 0, 1, 32'd0);
        add_row(ROW_CFG, 32'd65535, 13'(CFG_VOLUME), 0, 0, 0);
        add_row(ROW_CFG, 32'd8192, 13'(CFG_WAVE_LEN), 0, 0, 0);
        add_row(ROW_RENDER, 32'd1, 0, 0, 0, 0);
        add_row(ROW_RENDER, 32'd3, 0, 0, 0, 0);
        add_row(ROW_CFG, 32'd20, 13'(CFG_TABLE_LEN), 0, 0, 0);
        add_row(ROW_CFG, 32'd15, 13'(CFG_WAVE_LEN), 0, 0, 0);
        add_row(ROW_RENDER, 32'd7, 0, 0, 0, 0);
        add_row(ROW_CFG, 32'd0, 13'(CFG_WAVE_LEN), 0, 0, 0);
        add_row(ROW_RENDER, 32'd12345, 0, 0, 1, 32'h0000_7FFF);
        add_row(ROW_CFG, 32'hFF_FFFF, 13'(CFG_TABLE_LEN), 0, 0, 0);
        add_row(ROW_CFG, 32'd1, 13'(CFG_WAVE_LEN), 0, 0, 0);
        add_row(ROW_CFG, 32'd0, 13'(CFG_TABLE_MASK), 0, 0, 0);
        add_row(ROW_RENDER, 32'hABCD_EF01, 0, 0, 1, 32'h0000_7FFF);
        add_row(ROW_CFG, 32'd0, 13'(CFG_CH_COUNT), 0, 0, 0);
        add_row(ROW_RENDER, 32'd5, 0, 0, 0, 0);
        add_row(ROW_CFG, 32'd63, 13'(CFG_CH_COUNT), 0, 0, 0);
        add_row(ROW_CFG, 32'hAAAA_AAAA, 13'(CFG_CH_MASK), 0, 0, 0);
        add_row(ROW_RENDER, 32'd0, 0, 0, 0, 0);
        add_row(ROW_CFG, 32'hFFFF_FFFF, 13'(CFG_UNUSED), 0, 0, 0);

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[i]) begin
            case (rows[i].kind)
                ROW_LOAD:   send_word(OP_LOAD, rows[i].idx, rows[i].val, 32'($urandom), 0, 0);
                ROW_RENDER: send_render(rows[i].arg, rows[i].typed, rows[i].want);
                default: begin
                    wait_idle();
                    cfg_write(rows[i].idx[2:0], rows[i].arg);
                    cfg_valid <= 1'b0;
                    @(negedge i_clk);
                end
            endcase
        end

        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            idle_pct = phase_idle[ph];
            stall_pct = phase_stall[ph];
            if ($urandom_range(0, 99) < 60) begin
                cfg_write(CFG_TABLE_LEN, $urandom_range(1, 8192));
                cfg_write(CFG_WAVE_LEN, $urandom_range(1, 16384));
            end else begin
                cfg_write(CFG_TABLE_LEN, $urandom_range(1, 24'hFF_FFFF));
                cfg_write(CFG_WAVE_LEN, $urandom_range(1, 24'hFF_FFFF));
            end
            cfg_write(CFG_TABLE_MASK, ($urandom_range(0, 1) != 0) ? 4095 : $urandom_range(0, 4095));
            cfg_write(CFG_VOLUME, (ph == 0) ? 65535 : $urandom_range(0, 65535));
            case ($urandom_range(0, 9))
                0:       cfg_write(CFG_CH_COUNT, 32);
                1:       cfg_write(CFG_CH_COUNT, $urandom_range(0, 63));
                default: cfg_write(CFG_CH_COUNT, $urandom_range(1, 6));
            endcase
            cfg_write(CFG_CH_MASK, $urandom);
            cfg_write(CFG_OUT_FMT, ph);
            reg_idx = CFG_UNUSED;
            cfg_write(reg_idx, $urandom);
            cfg_valid <= 1'b0;
            @(negedge i_clk);
            for (int k = 0; k < 28; k++) begin
                if (k == 14) begin
                    s_tvalid <= 1'b0;
                    wait (pending_words.size() == 0);
                    @(negedge i_clk);
                end
                if ($urandom_range(0, 99) < 30) begin
                    send_word(OP_LOAD,
                              ($urandom_range(0, 9) == 0) ? 13'($urandom_range(4097, 8191))
                                                          : 13'($urandom_range(0, GUARD_IDX)),
                              16'($urandom), 32'($urandom), 0, 0);
                end else begin
                    send_render(($urandom_range(0, 3) == 0) ? $urandom_range(0, 64) : $urandom,
                                0, 0);
                end
            end
        end

        s_tvalid <= 1'b0;
        wait (pending_words.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0 && pending_words.size() == 0) begin
            $display("wavetable_oscillator_render_tb passed");
        end else begin
            $display("wavetable_oscillator_render_tb failed");
        end
        $finish;
    end

endmodule
